FILE: src/lfs_pkg.sv
`default_nettype none
package lfs_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int THR_W       = 10;
	localparam int LIMIT_W     = 7;
	localparam int DRIVE_W     = 9;
	localparam int SEG_W       = 7;
	localparam int SENS_W      = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 10;
	localparam int DIGITS      = 4;
	localparam int CMP_W       = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

	localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(970);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);
	localparam logic [LIMIT_W-1:0] LOST_MAX    = LIMIT_W'(127);

	localparam logic [DRIVE_W-1:0] DRIVE_HALT = DRIVE_W'(230);
	localparam logic [DRIVE_W-1:0] DRIVE_FAST = DRIVE_W'(258);
	localparam logic [DRIVE_W-1:0] DRIVE_SLOW = DRIVE_W'(155);
	localparam logic [DRIVE_W-1:0] DRIVE_MAX  = DRIVE_W'(312);
	localparam logic [DRIVE_W-1:0] DRIVE_TURN = DRIVE_W'(233);

	// sensor patterns, bit3 is sensor one
	localparam logic [SENS_W-1:0] SNS_NONE      = 4'b0000;
	localparam logic [SENS_W-1:0] SNS_CENTER    = 4'b1001;
	localparam logic [SENS_W-1:0] SNS_PAIR_HIGH = 4'b1100;
	localparam logic [SENS_W-1:0] SNS_PAIR_LOW  = 4'b0011;
	localparam logic [SENS_W-1:0] SNS_EDGE_HIGH = 4'b1000;
	localparam logic [SENS_W-1:0] SNS_EDGE_LOW  = 4'b0001;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_THR  = 2'd0,
		CFG_LOST_LIMIT = 2'd1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		MODE_IDLE       = 4'd0,
		MODE_STRAIGHT   = 4'd1,
		MODE_RIGHT      = 4'd2,
		MODE_HARD_RIGHT = 4'd3,
		MODE_LEFT       = 4'd5,
		MODE_HARD_LEFT  = 4'd6,
		MODE_STOP       = 4'd8
	} mode_t;

	typedef logic [3:0] digit_t;

	typedef struct packed {
		logic [SENS_W-1:0]      sensors;
		logic                   start_button;
		logic [SAMPLE_BITS-1:0] sound_sample;
	} item_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] left_compare;
		logic [DRIVE_W-1:0] right_compare;
		logic [3:0]         mode_now;
		logic [SEG_W-1:0]   ones_segments;
		logic [SEG_W-1:0]   tens_segments;
	} result_t;

	typedef struct packed {
		logic [THR_W-1:0]   start_thr;
		logic [LIMIT_W-1:0] lost_limit;
	} cfg_t;

	function automatic logic [SEG_W-1:0] seg7(input digit_t d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0:    s = 7'h3F;
			4'd1:    s = 7'h06;
			4'd2:    s = 7'h5B;
			4'd3:    s = 7'h4F;
			4'd4:    s = 7'h66;
			4'd5:    s = 7'h6D;
			4'd6:    s = 7'h7D;
			4'd7:    s = 7'h07;
			4'd8:    s = 7'h7F;
			4'd9:    s = 7'h6F;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

FILE: src/lfs_item_if.sv
`default_nettype none
interface lfs_item_if;
	import lfs_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [SENS_W-1:0]      sensors;
	logic                   start_button;
	logic [SAMPLE_BITS-1:0] sound_sample;

	modport source (output valid, output sensors, output start_button, output sound_sample,
		input ready);
	modport sink (input valid, input sensors, input start_button, input sound_sample,
		output ready);
endinterface
`default_nettype wire

FILE: src/lfs_result_if.sv
`default_nettype none
interface lfs_result_if;
	import lfs_pkg::*;

	logic               valid;
	logic               ready;
	logic [DRIVE_W-1:0] left_compare;
	logic [DRIVE_W-1:0] right_compare;
	logic [3:0]         mode_now;
	logic [SEG_W-1:0]   ones_segments;
	logic [SEG_W-1:0]   tens_segments;

	modport source (output valid, output left_compare, output right_compare,
		output mode_now, output ones_segments, output tens_segments, input ready);
	modport sink (input valid, input left_compare, input right_compare,
		input mode_now, input ones_segments, input tens_segments, output ready);
endinterface
`default_nettype wire

FILE: src/lfs_cfg_if.sv
`default_nettype none
interface lfs_cfg_if;
	import lfs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: src/line_follower_steering_fsm.sv
`default_nettype none
// Line-follower steering controller. Each transfer on item is one control pass; it yields
// exactly one transfer on result with the servo compare values, the new mode and the
// seven-segment codes of the distance shown in hundreds. The input transfer loads the
// input register; the mode logic then loads the result register when that is empty or
// being taken, so a stall on result holds the pass there. A new item is taken every cycle,
// limited only by the result ready.
// Registers on cfg (index 0 start sound threshold, 1 lost-line limit) are written
// directly and must only change while no item is in flight.
module line_follower_steering_fsm (
	input  wire logic clk,
	input  wire logic arst_n,
	lfs_item_if.sink     item,
	lfs_result_if.source result,
	lfs_cfg_if.sink      cfg
);
	import lfs_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	result_t res_next;
	cfg_t    cfg_q;
	logic    step;
	logic    take;

	assign step       = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || step;
	assign take       = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_thr  <= THR_RESET;
			cfg_q.lost_limit <= LIMIT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_START_THR:  cfg_q.start_thr  <= cfg.data[THR_W-1:0];
				CFG_LOST_LIMIT: cfg_q.lost_limit <= cfg.data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.sensors      <= item.sensors;
			item_s1.start_button <= item.start_button;
			item_s1.sound_sample <= item.sound_sample;
		end
		if (step) begin
			res_s2 <= res_next;
		end
	end

	lfs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_next)
	);

	assign result.valid         = valid_s2;
	assign result.left_compare  = res_s2.left_compare;
	assign result.right_compare = res_s2.right_compare;
	assign result.mode_now      = res_s2.mode_now;
	assign result.ones_segments = res_s2.ones_segments;
	assign result.tens_segments = res_s2.tens_segments;

endmodule
`default_nettype wire

FILE: src/lfs_core.sv
`default_nettype none
module lfs_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire lfs_pkg::item_t  item,
	input  wire lfs_pkg::cfg_t   cfg,
	output lfs_pkg::result_t     res
);
	import lfs_pkg::*;

	mode_t              mode_q, mode_d;
	digit_t             dist_q [DIGITS];
	digit_t             dist_d [DIGITS];
	logic [LIMIT_W-1:0] lost_q, lost_d;
	logic [DRIVE_W-1:0] left_q, left_d;
	logic [DRIVE_W-1:0] right_q, right_d;
	logic               start_go;
	logic               carry;

	assign start_go = item.start_button ||
		(CMP_W'(item.sound_sample) > CMP_W'(cfg.start_thr));

	always_comb begin
		mode_d  = mode_q;
		lost_d  = lost_q;
		left_d  = left_q;
		right_d = right_q;
		carry   = 1'b0;
		for (int i = 0; i < DIGITS; i++) begin
			dist_d[i] = dist_q[i];
		end

		unique case (mode_q)
			MODE_IDLE: begin
				for (int i = 0; i < DIGITS; i++) begin
					dist_d[i] = '0;
				end
				left_d  = DRIVE_HALT;
				right_d = DRIVE_HALT;
			end
			MODE_STRAIGHT, MODE_RIGHT, MODE_LEFT: begin
				// decimal counter, wraps at 10000
				carry = 1'b1;
				for (int i = 0; i < DIGITS; i++) begin
					if (carry) begin
						if (dist_q[i] == 4'd9) begin
							dist_d[i] = '0;
						end else begin
							dist_d[i] = dist_q[i] + 4'd1;
							carry     = 1'b0;
						end
					end
				end
				if (mode_q == MODE_STRAIGHT) begin
					left_d  = DRIVE_FAST;
					right_d = DRIVE_SLOW;
				end else if (mode_q == MODE_RIGHT) begin
					left_d  = DRIVE_MAX;
					right_d = DRIVE_TURN;
					lost_d  = '0;
				end else begin
					left_d  = DRIVE_TURN;
					right_d = DRIVE_SLOW;
					lost_d  = '0;
				end
			end
			MODE_HARD_RIGHT: begin
				left_d  = DRIVE_FAST;
				right_d = DRIVE_FAST;
				lost_d  = '0;
			end
			MODE_HARD_LEFT: begin
				left_d  = DRIVE_SLOW;
				right_d = DRIVE_SLOW;
				lost_d  = '0;
			end
			default: ;
		endcase

		unique case (mode_q)
			MODE_IDLE: begin
				if (start_go) mode_d = MODE_STRAIGHT;
			end
			MODE_STRAIGHT: begin
				case (item.sensors)
					SNS_PAIR_HIGH: mode_d = MODE_RIGHT;
					SNS_PAIR_LOW:  mode_d = MODE_LEFT;
					SNS_EDGE_LOW:  mode_d = MODE_HARD_LEFT;
					SNS_EDGE_HIGH: mode_d = MODE_HARD_RIGHT;
					SNS_NONE:      mode_d = MODE_STOP;
					default: ;
				endcase
			end
			MODE_LEFT: begin
				case (item.sensors)
					SNS_CENTER:    mode_d = MODE_STRAIGHT;
					SNS_PAIR_HIGH: mode_d = MODE_RIGHT;
					SNS_EDGE_LOW:  mode_d = MODE_HARD_LEFT;
					SNS_EDGE_HIGH: mode_d = MODE_HARD_RIGHT;
					SNS_NONE:      mode_d = MODE_STOP;
					default: ;
				endcase
			end
			MODE_RIGHT: begin
				case (item.sensors)
					SNS_CENTER:    mode_d = MODE_STRAIGHT;
					SNS_PAIR_LOW:  mode_d = MODE_LEFT;
					SNS_EDGE_HIGH: mode_d = MODE_HARD_RIGHT;
					SNS_EDGE_LOW:  mode_d = MODE_HARD_LEFT;
					SNS_NONE:      mode_d = MODE_STOP;
					default: ;
				endcase
			end
			MODE_HARD_RIGHT: begin
				case (item.sensors)
					SNS_CENTER:    mode_d = MODE_STRAIGHT;
					SNS_EDGE_LOW:  mode_d = MODE_HARD_LEFT;
					SNS_PAIR_LOW:  mode_d = MODE_LEFT;
					SNS_EDGE_HIGH: mode_d = MODE_RIGHT;
					SNS_NONE:      mode_d = MODE_STOP;
					default: ;
				endcase
			end
			MODE_HARD_LEFT: begin
				case (item.sensors)
					SNS_CENTER:    mode_d = MODE_STRAIGHT;
					SNS_EDGE_HIGH: mode_d = MODE_HARD_RIGHT;
					SNS_PAIR_HIGH: mode_d = MODE_RIGHT;
					SNS_EDGE_LOW:  mode_d = MODE_LEFT;
					SNS_NONE:      mode_d = MODE_STOP;
					default: ;
				endcase
			end
			MODE_STOP: begin
				if (lost_q >= cfg.lost_limit) begin
					left_d  = DRIVE_HALT;
					right_d = DRIVE_HALT;
					lost_d  = '0;
					mode_d  = MODE_IDLE;
				end else begin
					mode_d = MODE_STRAIGHT;
				end
			end
			default: mode_d = MODE_IDLE;
		endcase

		// line lost from a driving mode, count saturates
		if (mode_q != MODE_IDLE && mode_q != MODE_STOP && mode_d == MODE_STOP &&
				lost_d != LOST_MAX) begin
			lost_d = lost_d + LIMIT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			lost_q  <= '0;
			left_q  <= DRIVE_HALT;
			right_q <= DRIVE_HALT;
			for (int i = 0; i < DIGITS; i++) begin
				dist_q[i] <= '0;
			end
		end else if (step) begin
			mode_q  <= mode_d;
			lost_q  <= lost_d;
			left_q  <= left_d;
			right_q <= right_d;
			for (int i = 0; i < DIGITS; i++) begin
				dist_q[i] <= dist_d[i];
			end
		end
	end

	// displayed value is the hundreds and thousands digits
	assign res.left_compare  = left_d;
	assign res.right_compare = right_d;
	assign res.mode_now      = mode_d;
	assign res.ones_segments = seg7(dist_d[2]);
	assign res.tens_segments = seg7(dist_d[3]);

	a_idle_clears_dist: assert property (@(posedge clk) disable iff (!arst_n)
		step && mode_q == MODE_IDLE |=> dist_q[0] == '0 && dist_q[1] == '0 &&
			dist_q[2] == '0 && dist_q[3] == '0)
		else $error("distance not cleared by idle pass");

	a_stop_exits: assert property (@(posedge clk) disable iff (!arst_n)
		step && mode_q == MODE_STOP |=> mode_q == MODE_IDLE || mode_q == MODE_STRAIGHT)
		else $error("stop mode did not leave to idle or straight");

	a_digits_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		dist_q[0] <= 4'd9 && dist_q[1] <= 4'd9 && dist_q[2] <= 4'd9 && dist_q[3] <= 4'd9)
		else $error("distance digit out of decimal range");

	a_hold_without_step: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(mode_q) && $stable(lost_q) && $stable(left_q))
		else $error("state changed without a pass");

endmodule
`default_nettype wire

FILE: tb/line_follower_steering_fsm_tb.sv
`default_nettype none
module line_follower_steering_fsm_tb;
	import lfs_pkg::*;

	localparam int ROW_COUNT = 26;
	localparam int PHASES = 5;
	localparam int RANDOM_PER_PHASE = 350;
	localparam int LONG_PHASE = 3;
	localparam int LONG_HAUL = 200;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

	localparam logic [SEG_W-1:0] DIGIT_SEGS [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};
	localparam logic [SENS_W-1:0] TRACK_PATTERNS [5] = '{
		SNS_CENTER, SNS_PAIR_HIGH, SNS_PAIR_LOW, SNS_EDGE_HIGH, SNS_EDGE_LOW
	};

	// start threshold and raw lost-limit data per phase; high bits of the limit data are dropped
	localparam logic [CFG_DATA_W-1:0] PH_THR [PHASES] = '{10'd0, 10'd1023, 10'd512, 10'd970, 10'd1};
	localparam logic [CFG_DATA_W-1:0] PH_LIMIT [PHASES] = '{10'd1, 10'd127, 10'h380, 10'd100, 10'h3C5};

	typedef struct packed {
		logic [SENS_W-1:0]      sensors;
		logic                   start_button;
		logic [SAMPLE_BITS-1:0] sound_sample;
		logic                   typed;
		result_t                want;
	} pass_row_t;

	localparam result_t UNTYPED = '0;

	localparam pass_row_t STEER_ROWS [ROW_COUNT] = '{
		'{4'hF, 1'b0, 10'd0, 1'b1,
			'{DRIVE_HALT, DRIVE_HALT, MODE_IDLE, DIGIT_SEGS[0], DIGIT_SEGS[0]}},
		// sound exactly at threshold does not start
		'{SNS_NONE, 1'b0, 10'd970, 1'b1,
			'{DRIVE_HALT, DRIVE_HALT, MODE_IDLE, DIGIT_SEGS[0], DIGIT_SEGS[0]}},
		'{SNS_NONE, 1'b0, 10'd971, 1'b1,
			'{DRIVE_HALT, DRIVE_HALT, MODE_STRAIGHT, DIGIT_SEGS[0], DIGIT_SEGS[0]}},
		'{SNS_PAIR_HIGH, 1'b0, 10'd0, 1'b1,
			'{DRIVE_FAST, DRIVE_SLOW, MODE_RIGHT, DIGIT_SEGS[0], DIGIT_SEGS[0]}},
		'{SNS_PAIR_LOW, 1'b0, 10'd0, 1'b1,
			'{DRIVE_MAX, DRIVE_TURN, MODE_LEFT, DIGIT_SEGS[0], DIGIT_SEGS[0]}},
		'{SNS_CENTER, 1'b0, 10'd1023, 1'b0, UNTYPED},
		'{SNS_EDGE_LOW, 1'b1, 10'd0, 1'b0, UNTYPED},
		'{SNS_EDGE_HIGH, 1'b0, 10'd0, 1'b0, UNTYPED},
		'{SNS_EDGE_HIGH, 1'b0, 10'd0, 1'b0, UNTYPED},
		'{SNS_EDGE_LOW, 1'b0, 10'd0, 1'b0, UNTYPED},
		'{SNS_PAIR_HIGH, 1'b0, 10'd0, 1'b0, UNTYPED},
		'{SNS_EDGE_HIGH, 1'b0, 10'd0, 1'b0, UNTYPED},
		'{SNS_EDGE_LOW, 1'b0, 10'd0, 1'b0, UNTYPED},
		'{SNS_EDGE_LOW, 1'b0, 10'd0, 1'b0, UNTYPED},
		'{SNS_PAIR_HIGH, 1'b0, 10'd0, 1'b0, UNTYPED},
		'{SNS_CENTER, 1'b0, 10'd0, 1'b0, UNTYPED},
		'{SNS_EDGE_HIGH, 1'b0, 10'd0, 1'b0, UNTYPED},
		'{SNS_PAIR_LOW, 1'b0, 10'd0, 1'b0, UNTYPED},
		'{SNS_EDGE_LOW, 1'b0, 10'd0, 1'b0, UNTYPED},
		'{SNS_CENTER, 1'b0, 10'd0, 1'b0, UNTYPED},
		'{SNS_PAIR_LOW, 1'b0, 10'd0, 1'b0, UNTYPED},
		'{SNS_EDGE_HIGH, 1'b0, 10'd0, 1'b0, UNTYPED},
		'{SNS_CENTER, 1'b0, 10'd0, 1'b0, UNTYPED},
		// pattern outside the table keeps the mode
		'{4'b0110, 1'b0, 10'd0, 1'b0, UNTYPED},
		'{SNS_NONE, 1'b0, 10'd0, 1'b0, UNTYPED},
		'{4'hF, 1'b1, 10'd1023, 1'b0, UNTYPED}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic steady;
	logic row_typed;
	result_t row_want;

	lfs_item_if   item_ch();
	lfs_result_if result_ch();
	lfs_cfg_if    cfg_ch();

	line_follower_steering_fsm u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// predictor copy of the block state and settings
	mode_t                drv_mode   = MODE_IDLE;
	logic [13:0]          trip_dist  = '0;
	logic [LIMIT_W-1:0]   lost_cnt   = '0;
	logic [DRIVE_W-1:0]   left_cmp   = DRIVE_HALT;
	logic [DRIVE_W-1:0]   right_cmp  = DRIVE_HALT;
	logic [THR_W-1:0]     start_thr  = THR_RESET;
	logic [LIMIT_W-1:0]   lost_limit = LIMIT_RESET;

	result_t pending_steer [$];
	int pass_count = 0;
	int result_count = 0;
	int miss_count = 0;
	int shutdown_count = 0;
	int wrap_count = 0;
	int top_shown = 0;

	task automatic advance_trip();
		if (trip_dist == 14'd9999) begin
			trip_dist = '0;
			wrap_count++;
		end else begin
			trip_dist = trip_dist + 14'd1;
		end
	endtask

	task automatic lose_line();
		if (lost_cnt != LOST_MAX)
			lost_cnt = lost_cnt + LIMIT_W'(1);
		drv_mode = MODE_STOP;
	endtask

	task automatic steer_pass(input logic [SENS_W-1:0] s, input logic btn,
		input logic [SAMPLE_BITS-1:0] smp, output result_t r);
		mode_t cur;
		int shown;
		cur = drv_mode;
		case (cur)
			MODE_IDLE: begin
				trip_dist = '0;
				left_cmp = DRIVE_HALT;
				right_cmp = DRIVE_HALT;
			end
			MODE_STRAIGHT: begin
				left_cmp = DRIVE_FAST;
				right_cmp = DRIVE_SLOW;
				advance_trip();
			end
			MODE_RIGHT: begin
				left_cmp = DRIVE_MAX;
				right_cmp = DRIVE_TURN;
				advance_trip();
				lost_cnt = '0;
			end
			MODE_LEFT: begin
				left_cmp = DRIVE_TURN;
				right_cmp = DRIVE_SLOW;
				advance_trip();
				lost_cnt = '0;
			end
			MODE_HARD_RIGHT: begin
				left_cmp = DRIVE_FAST;
				right_cmp = DRIVE_FAST;
				lost_cnt = '0;
			end
			MODE_HARD_LEFT: begin
				left_cmp = DRIVE_SLOW;
				right_cmp = DRIVE_SLOW;
				lost_cnt = '0;
			end
			default: ;
		endcase

		case (cur)
			MODE_IDLE: begin
				if (btn || smp > start_thr)
					drv_mode = MODE_STRAIGHT;
			end
			MODE_STRAIGHT: begin
				if (s == SNS_PAIR_HIGH) drv_mode = MODE_RIGHT;
				else if (s == SNS_PAIR_LOW) drv_mode = MODE_LEFT;
				else if (s == SNS_EDGE_LOW) drv_mode = MODE_HARD_LEFT;
				else if (s == SNS_EDGE_HIGH) drv_mode = MODE_HARD_RIGHT;
				else if (s == SNS_NONE) lose_line();
			end
			MODE_LEFT: begin
				if (s == SNS_CENTER) drv_mode = MODE_STRAIGHT;
				else if (s == SNS_PAIR_HIGH) drv_mode = MODE_RIGHT;
				else if (s == SNS_EDGE_LOW) drv_mode = MODE_HARD_LEFT;
				else if (s == SNS_EDGE_HIGH) drv_mode = MODE_HARD_RIGHT;
				else if (s == SNS_NONE) lose_line();
			end
			MODE_RIGHT: begin
				if (s == SNS_CENTER) drv_mode = MODE_STRAIGHT;
				else if (s == SNS_PAIR_LOW) drv_mode = MODE_LEFT;
				else if (s == SNS_EDGE_HIGH) drv_mode = MODE_HARD_RIGHT;
				else if (s == SNS_EDGE_LOW) drv_mode = MODE_HARD_LEFT;
				else if (s == SNS_NONE) lose_line();
			end
			MODE_HARD_RIGHT: begin
				if (s == SNS_CENTER) drv_mode = MODE_STRAIGHT;
				else if (s == SNS_EDGE_LOW) drv_mode = MODE_HARD_LEFT;
				else if (s == SNS_PAIR_LOW) drv_mode = MODE_LEFT;
				else if (s == SNS_EDGE_HIGH) drv_mode = MODE_RIGHT;
				else if (s == SNS_NONE) lose_line();
			end
			MODE_HARD_LEFT: begin
				if (s == SNS_CENTER) drv_mode = MODE_STRAIGHT;
				else if (s == SNS_EDGE_HIGH) begin
					drv_mode = MODE_HARD_RIGHT;
					lost_cnt = '0;
				end else if (s == SNS_PAIR_HIGH) begin
					drv_mode = MODE_RIGHT;
					lost_cnt = '0;
				end else if (s == SNS_EDGE_LOW) begin
					drv_mode = MODE_LEFT;
					lost_cnt = '0;
				end else if (s == SNS_NONE) lose_line();
			end
			MODE_STOP: begin
				// enough losses end the run
				if (lost_cnt >= lost_limit) begin
					left_cmp = DRIVE_HALT;
					right_cmp = DRIVE_HALT;
					drv_mode = MODE_IDLE;
					lost_cnt = '0;
					shutdown_count++;
				end else begin
					drv_mode = MODE_STRAIGHT;
				end
			end
			default: drv_mode = MODE_IDLE;
		endcase

		shown = (int'(trip_dist) / 100) % 100;
		if (shown > top_shown)
			top_shown = shown;
		r.left_compare = left_cmp;
		r.right_compare = right_cmp;
		r.mode_now = drv_mode;
		r.ones_segments = DIGIT_SEGS[shown % 10];
		r.tens_segments = DIGIT_SEGS[shown / 10];
	endtask

	task automatic report_miss(input string what, input logic [15:0] got, input logic [15:0] want);
		miss_count++;
		if (miss_count <= 40)
			$display("result %0d: %s got %0d expected %0d", result_count, what, got, want);
	endtask

	// sampled at the falling edge: a transfer seen here completes at the next rising edge
	always @(negedge clk) begin
		result_t want;
		if (arst_n) begin
			if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
				if (cfg_ch.index == CFG_START_THR)
					start_thr = cfg_ch.data[THR_W-1:0];
				else if (cfg_ch.index == CFG_LOST_LIMIT)
					lost_limit = cfg_ch.data[LIMIT_W-1:0];
			end
			if (item_ch.valid === 1'b1 && item_ch.ready === 1'b1) begin
				steer_pass(item_ch.sensors, item_ch.start_button, item_ch.sound_sample, want);
				pending_steer.push_back(row_typed ? row_want : want);
				pass_count++;
			end
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				if (pending_steer.size() == 0) begin
					report_miss("unexpected transfer", '0, '0);
				end else begin
					want = pending_steer.pop_front();
					if (result_ch.left_compare !== want.left_compare)
						report_miss("left_compare", 16'(result_ch.left_compare),
							16'(want.left_compare));
					if (result_ch.right_compare !== want.right_compare)
						report_miss("right_compare", 16'(result_ch.right_compare),
							16'(want.right_compare));
					if (result_ch.mode_now !== want.mode_now)
						report_miss("mode_now", 16'(result_ch.mode_now), 16'(want.mode_now));
					if (result_ch.ones_segments !== want.ones_segments)
						report_miss("ones_segments", 16'(result_ch.ones_segments),
							16'(want.ones_segments));
					if (result_ch.tens_segments !== want.tens_segments)
						report_miss("tens_segments", 16'(result_ch.tens_segments),
							16'(want.tens_segments));
				end
				result_count++;
			end
		end
	end

	// result side: random stalls except during steady stretches
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= steady || ($urandom_range(99) >= 12);
		end
	end

	task automatic send_pass(input logic [SENS_W-1:0] s, input logic btn,
		input logic [SAMPLE_BITS-1:0] smp, input logic typed, input result_t want);
		logic taken;
		while (!steady && $urandom_range(99) < 12) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.sensors <= s;
		item_ch.start_button <= btn;
		item_ch.sound_sample <= smp;
		row_typed <= typed;
		row_want <= want;
		do begin
			@(negedge clk);
			taken = (item_ch.ready === 1'b1);
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		logic taken;
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do begin
			@(negedge clk);
			taken = (cfg_ch.ready === 1'b1);
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_steer.size() != 0);
	endtask

	initial begin
		int k;
		int ph;
		int burst;
		logic [SENS_W-1:0] s;
		logic btn;
		logic [SAMPLE_BITS-1:0] smp;
		arst_n = 1'b0;
		steady = 1'b0;
		row_typed = 1'b0;
		row_want = '0;
		item_ch.valid = 1'b0;
		item_ch.sensors = '0;
		item_ch.start_button = 1'b0;
		item_ch.sound_sample = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_START_THR;
		cfg_ch.data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < ROW_COUNT; k++)
			send_pass(STEER_ROWS[k].sensors, STEER_ROWS[k].start_button,
				STEER_ROWS[k].sound_sample, STEER_ROWS[k].typed, STEER_ROWS[k].want);

		for (ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			repeat (4) @(posedge clk);
			write_reg(CFG_START_THR, PH_THR[ph]);
			write_reg(CFG_LOST_LIMIT, PH_LIMIT[ph]);
			// write to an unused index must leave both settings alone
			if (ph == 0)
				write_reg(CFG_SPARE_IDX, 10'h3FF);
			cfg_ch.valid <= 1'b0;
			@(posedge clk);

			burst = 0;
			for (k = 0; k < RANDOM_PER_PHASE; k++) begin
				if (ph == 1 && k == RANDOM_PER_PHASE / 2)
					wait_drained();
				// runs of lost line long enough to reach the limit through stop
				if (burst == 0 && $urandom_range(99) < 2)
					burst = 2 * int'(lost_limit) + 4;
				if (burst != 0) begin
					s = SNS_NONE;
					burst--;
				end else if ($urandom_range(99) < 80) begin
					s = ($urandom_range(5) == 0) ? SNS_NONE : TRACK_PATTERNS[$urandom_range(4)];
				end else begin
					s = SENS_W'($urandom_range(15));
				end
				btn = ($urandom_range(99) < 8);
				if ($urandom_range(99) < 25)
					smp = SAMPLE_BITS'(start_thr) + SAMPLE_BITS'($urandom_range(2)) -
						SAMPLE_BITS'(1);
				else
					smp = SAMPLE_BITS'($urandom_range(1023));
				send_pass(s, btn, smp, 1'b0, UNTYPED);
			end

			// long straight run with no idling on either side
			if (ph == LONG_PHASE) begin
				steady <= 1'b1;
				for (k = 0; k < LONG_HAUL; k++)
					send_pass(SNS_CENTER, 1'b1, SAMPLE_BITS'($urandom_range(1023)), 1'b0, UNTYPED);
				steady <= 1'b0;
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("covered %0d control passes, %0d results checked, %0d settings",
			pass_count, result_count, PHASES + 1);
		$display("lost-line shutdowns %0d, distance wraps %0d, highest display %0d",
			shutdown_count, wrap_count, top_shown);
		if (miss_count == 0) begin
			$display("line_follower_steering_fsm: match");
		end else begin
			$display("line_follower_steering_fsm: mismatch");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("line_follower_steering_fsm: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
